// File: rtl/core/lspd_pkg.sv
// Package for the lidar scan packet deframer core.
// Holds the descriptor pattern, packet layout offsets and stream widths.
// No dependencies.
package lspd_pkg;

    // Scan reply descriptor that unlocks the deframer after reset.
    localparam int unsigned DESC_LEN = 7;

    // Packet header layout, byte offsets within the packet.
    localparam int unsigned HDR_LEN = 10;
    localparam logic [3:0] POS_HEADER_LO = 4'd0;
    localparam logic [3:0] POS_HEADER_HI = 4'd1;
    localparam logic [3:0] POS_TYPE      = 4'd2;
    localparam logic [3:0] POS_COUNT     = 4'd3;
    localparam logic [3:0] POS_START_LO  = 4'd4;
    localparam logic [3:0] POS_START_HI  = 4'd5;
    localparam logic [3:0] POS_END_LO    = 4'd6;
    localparam logic [3:0] POS_END_HI    = 4'd7;
    localparam logic [3:0] POS_CHECK_LO  = 4'd8;
    localparam logic [3:0] POS_CHECK_HI  = 4'd9;

    // Width of the packet byte counter and of the payload offset.
    localparam int unsigned POS_W    = 10;
    localparam int unsigned OFFSET_W = 9;

    // Result stream widths.
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned OUT_USER_W = 2;

    // Result tuser bit positions.
    localparam int unsigned USER_HAS_SAMPLE = 0;
    localparam int unsigned USER_USABLE     = 1;

    // Descriptor byte at a given match index.
    function automatic logic [7:0] desc_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hA5;
            3'd1:    b = 8'h5A;
            3'd2:    b = 8'h05;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h00;
            3'd5:    b = 8'h40;
            3'd6:    b = 8'h81;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/lidar_scan_packet_deframer_core.sv
// Top level of the lidar scan packet deframer core.
// Hunts for the scan reply descriptor, then deframes packets into sample transfers.
// Depends on lspd_pkg and lspd_hunt.
//
//  Channel  Dir  Width     Contents
//  s_axis   in   8         rx_byte
//  m_axis   out  104+2+1   tdata: packed sample and header fields, tuser: flags,
//                          tlast: frame_last
//
// One byte is taken per cycle whenever the result register is empty or is being
// drained in the same cycle; the path from the packet byte counter and the header
// capture registers into the single result register sets this rate.
// A result appears on m_axis in the cycle after the byte that causes it.
// Reset (rst_n, asynchronous, active low) clears the hunt, the byte counter and the
// result valid flag. A stalled m_axis holds its transfer and stalls s_axis only when
// the result register is full.
module lidar_scan_packet_deframer_core
    import lspd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] sample_byte, [16:8] sample_position, [32:17] packet_header,
    // [40:33] packet_type, [48:41] sample_count, [64:49] start_angle,
    // [80:65] end_angle, [96:81] check_word, [103:97] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [OUT_USER_W-1:0] m_axis_tuser,   // [0] has_sample, [1] frame_usable
    output logic                  m_axis_tlast    // frame_last
);

    logic in_xfer;
    logic locked;

    // Packet byte counter and captured header fields.
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      header_reg;
    logic [15:0]      header_next;
    logic [7:0]       type_reg;
    logic [7:0]       type_next;
    logic [7:0]       count_reg;
    logic [7:0]       count_next;
    logic [15:0]      start_reg;
    logic [15:0]      start_next;
    logic [15:0]      end_reg;
    logic [15:0]      end_next;
    logic [15:0]      check_reg;
    logic [15:0]      check_next;

    // Result register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_has_reg;
    logic [7:0]          out_byte_reg;
    logic [OFFSET_W-1:0] out_pos_reg;
    logic [15:0]         out_header_reg;
    logic [7:0]          out_type_reg;
    logic [7:0]          out_count_reg;
    logic [15:0]         out_start_reg;
    logic [15:0]         out_end_reg;
    logic [15:0]         out_check_reg;
    logic                out_last_reg;
    logic                out_usable_reg;

    // Result of the byte now being taken.
    logic                res_valid;
    logic                res_has;
    logic [7:0]          res_byte;
    logic [POS_W-1:0]    res_offset;
    logic                res_last;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Bytes go to the hunter until the descriptor has been seen.
    lspd_hunt u_hunt
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (in_xfer),
        .byte_data  (s_axis_tdata),
        .locked     (locked)
    );

    always_comb
    begin
        pos_next    = pos_reg;
        header_next = header_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        check_next  = check_reg;
        res_valid   = 1'b0;
        res_has     = 1'b0;
        res_byte    = 8'd0;
        res_offset  = '0;
        res_last    = 1'b0;

        if (in_xfer && locked)
        begin
            if (pos_reg < POS_W'(HDR_LEN))
            begin
                // Header bytes are captured in place; multi-byte fields are little-endian.
                case (pos_reg[3:0])
                    POS_HEADER_LO: header_next = {header_reg[15:8], s_axis_tdata};
                    POS_HEADER_HI: header_next = {s_axis_tdata, header_reg[7:0]};
                    POS_TYPE:      type_next   = s_axis_tdata;
                    POS_COUNT:     count_next  = s_axis_tdata;
                    POS_START_LO:  start_next  = {start_reg[15:8], s_axis_tdata};
                    POS_START_HI:  start_next  = {s_axis_tdata, start_reg[7:0]};
                    POS_END_LO:    end_next    = {end_reg[15:8], s_axis_tdata};
                    POS_END_HI:    end_next    = {s_axis_tdata, end_reg[7:0]};
                    POS_CHECK_LO:  check_next  = {check_reg[15:8], s_axis_tdata};
                    POS_CHECK_HI:  check_next  = {s_axis_tdata, check_reg[7:0]};
                    default:       check_next  = check_reg;
                endcase
                // An empty packet closes on its last check-word byte with a marker result.
                if ((pos_reg[3:0] == POS_CHECK_HI) && (count_reg == 8'd0))
                begin
                    res_valid = 1'b1;
                    res_last  = 1'b1;
                    pos_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                // Payload byte: its offset runs from zero to twice the sample count less one.
                res_valid  = 1'b1;
                res_has    = 1'b1;
                res_byte   = s_axis_tdata;
                res_offset = pos_reg - POS_W'(HDR_LEN);
                res_last   = ((res_offset + POS_W'(1)) >= {1'b0, count_reg, 1'b0});
                pos_next   = res_last ? '0 : (pos_reg + POS_W'(1));
            end
        end

        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Header capture and result payload need no reset: every field is written
    // before any result can use it.
    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        type_reg   <= type_next;
        count_reg  <= count_next;
        start_reg  <= start_next;
        end_reg    <= end_next;
        check_reg  <= check_next;
        if (res_valid)
        begin
            out_has_reg    <= res_has;
            out_byte_reg   <= res_byte;
            out_pos_reg    <= res_offset[OFFSET_W-1:0];
            out_header_reg <= header_next;
            out_type_reg   <= type_next;
            out_count_reg  <= count_next;
            out_start_reg  <= start_next;
            out_end_reg    <= end_next;
            out_check_reg  <= check_next;
            out_last_reg   <= res_last;
            out_usable_reg <= (count_next > 8'd1);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_check_reg, out_end_reg, out_start_reg, out_count_reg,
                            out_type_reg, out_header_reg, out_pos_reg, out_byte_reg};
    assign m_axis_tuser  = {out_usable_reg, out_has_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: rtl/core/lspd_hunt.sv
// Descriptor hunter for the lidar scan packet deframer core.
// Watches accepted bytes after reset until the scan reply descriptor is seen.
// Depends on lspd_pkg.
module lspd_hunt
    import lspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       locked
);

    logic       hunting_reg;
    logic       hunting_next;
    logic [2:0] match_reg;
    logic [2:0] match_next;
    logic [2:0] match_cur;
    logic [3:0] match_inc;

    always_comb
    begin
        hunting_next = hunting_reg;
        match_next   = match_reg;
        match_cur    = (match_reg >= 3'(DESC_LEN)) ? 3'd0 : match_reg;
        match_inc    = 4'd0;
        if (byte_valid && hunting_reg)
        begin
            // A mismatch restarts the match; the descriptor's first byte appears only once.
            if (byte_data == desc_byte(match_cur))
            begin
                match_inc = {1'b0, match_cur} + 4'd1;
            end
            else if (byte_data == desc_byte(3'd0))
            begin
                match_inc = 4'd1;
            end
            if (match_inc >= 4'(DESC_LEN))
            begin
                hunting_next = 1'b0;
                match_next   = 3'd0;
            end
            else
            begin
                match_next = match_inc[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            match_reg   <= 3'd0;
        end
        else
        begin
            hunting_reg <= hunting_next;
            match_reg   <= match_next;
        end
    end

    assign locked = !hunting_reg;

endmodule

// File: rtl/core/lspd_checker.sv
// Port-level checker for the lidar scan packet deframer core, bound to the top level.
// Depends on lspd_pkg and lidar_scan_packet_deframer_core.
module lspd_checker
    import lspd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // A stalled result transfer stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result transfer dropped while stalled");

    // A stalled result transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        ($stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast)))
        else $error("result payload changed while stalled");

    // Input is held off only when a finished result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with room in the result register");

    // The empty frame marker ends its frame, is unusable and carries offset zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[USER_HAS_SAMPLE]) |->
        (m_axis_tlast && !m_axis_tuser[USER_USABLE] && (m_axis_tdata[16:0] == 17'd0)))
        else $error("malformed empty frame marker");

endmodule

bind lidar_scan_packet_deframer_core lspd_checker u_lspd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb_lidar_scan_packet_deframer_core.sv
// Testbench for lidar_scan_packet_deframer_core: feeds a byte stream through the descriptor
// hunt and packet deframing, predicts every sample transfer and checks it field by field.
// Depends on lspd_pkg and the core RTL.
module tb_lidar_scan_packet_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lspd_pkg::*;

    localparam int CLK_HALF_NS            = 2;
    localparam int TIMEOUT_NS             = 2_000_000;
    localparam int HOLD_CYCLES            = 400;
    localparam int DRAIN_CYCLES           = 8;
    localparam int RANDOM_BYTES_PER_PHASE = 160;

    // Scan reply descriptor in stream order, first byte in the top bits.
    localparam logic [DESC_LEN*8-1:0] SCAN_DESCRIPTOR =
        {8'hA5, 8'h5A, 8'h05, 8'h00, 8'h00, 8'h40, 8'h81};
    localparam logic [7:0] DESC_FIRST = 8'hA5;

    // Bytes sent before the first packet, in stream order. They walk the hunt through
    // stray bytes, a partial match broken by A5, a repeated A5, a match broken near its
    // end by a plain byte, one broken at its last byte by A5, and finally the lock.
    localparam int HUNT_LEN = 26;
    localparam logic [HUNT_LEN*8-1:0] HUNT_PREAMBLE = {
        8'h00, 8'h81,
        8'hA5, 8'h5A, 8'h05, 8'h00, 8'hA5,
        8'hA5, 8'h5A, 8'h05, 8'h00, 8'h00, 8'h00,
        8'hA5, 8'h5A, 8'h05, 8'h00, 8'h00, 8'h40, 8'hA5,
        8'h5A, 8'h05, 8'h00, 8'h00, 8'h40, 8'h81};

    typedef struct {
        logic        has_sample;
        logic [7:0]  sample_byte;
        logic [8:0]  sample_position;
        logic [15:0] packet_header;
        logic [7:0]  packet_type;
        logic [7:0]  sample_count;
        logic [15:0] start_angle;
        logic [15:0] end_angle;
        logic [15:0] check_word;
        logic        frame_last;
        logic        frame_usable;
    } sample_xfer_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  m_axis_tlast;

    // Pending bytes for the sender and the transfers the deframer still owes us.
    logic [7:0]   rx_stream_q [$];
    sample_xfer_t sample_expect_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_request = 1'b0;
    logic        hold_done = 1'b0;
    logic        hold_off = 1'b0;

    int unsigned error_count = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned samples_checked = 0;
    int unsigned frames_closed = 0;
    int unsigned empty_frames = 0;

    // Predicted deframer state.
    logic        sync_hunting = 1'b1;
    logic [2:0]  sync_match = 3'd0;
    logic [9:0]  pkt_offset = 10'd0;
    logic [15:0] hdr_word = 16'h0000;
    logic [7:0]  hdr_type = 8'h00;
    logic [7:0]  hdr_count = 8'h00;
    logic [15:0] hdr_start_angle = 16'h0000;
    logic [15:0] hdr_end_angle = 16'h0000;
    logic [15:0] hdr_check = 16'h0000;

    lidar_scan_packet_deframer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF_NS clk = ~clk;

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
        begin
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
        end
    endtask

    // Header fields as captured so far; every transfer carries them.
    function automatic sample_xfer_t captured_header();
        sample_xfer_t r;
        r.has_sample      = 1'b0;
        r.sample_byte     = 8'h00;
        r.sample_position = 9'd0;
        r.packet_header   = hdr_word;
        r.packet_type     = hdr_type;
        r.sample_count    = hdr_count;
        r.start_angle     = hdr_start_angle;
        r.end_angle       = hdr_end_angle;
        r.check_word      = hdr_check;
        r.frame_last      = 1'b0;
        r.frame_usable    = (hdr_count > 8'd1);
        return r;
    endfunction

    // Advances the predicted deframer by one accepted byte and queues any transfer it causes.
    task automatic deframe_byte(input logic [7:0] rx);
        int unsigned  m;
        int unsigned  off;
        sample_xfer_t r;
        if (sync_hunting)
        begin
            m = sync_match;
            if (m >= DESC_LEN)
            begin
                m = 0;
            end
            if (rx == SCAN_DESCRIPTOR[(DESC_LEN-1-m)*8 +: 8])
            begin
                m++;
            end
            else
            begin
                // A5 appears only once in the descriptor, so it restarts the match.
                m = (rx == DESC_FIRST) ? 1 : 0;
            end
            if (m >= DESC_LEN)
            begin
                sync_hunting = 1'b0;
                sync_match   = 3'd0;
                pkt_offset   = 10'd0;
            end
            else
            begin
                sync_match = m[2:0];
            end
        end
        else if (pkt_offset < HDR_LEN)
        begin
            case (pkt_offset[3:0])
                POS_HEADER_LO: hdr_word = {8'h00, rx};
                POS_HEADER_HI: hdr_word[15:8] = rx;
                POS_TYPE:      hdr_type = rx;
                POS_COUNT:     hdr_count = rx;
                POS_START_LO:  hdr_start_angle = {8'h00, rx};
                POS_START_HI:  hdr_start_angle[15:8] = rx;
                POS_END_LO:    hdr_end_angle = {8'h00, rx};
                POS_END_HI:    hdr_end_angle[15:8] = rx;
                POS_CHECK_LO:  hdr_check = {8'h00, rx};
                default:       hdr_check[15:8] = rx;
            endcase
            if (pkt_offset[3:0] == POS_CHECK_HI && hdr_count == 8'd0)
            begin
                // An empty packet closes on its last header byte.
                r = captured_header();
                r.frame_last = 1'b1;
                sample_expect_q.push_back(r);
                pkt_offset = 10'd0;
            end
            else
            begin
                pkt_offset = pkt_offset + 10'd1;
            end
        end
        else
        begin
            off = pkt_offset - HDR_LEN;
            r = captured_header();
            r.has_sample      = 1'b1;
            r.sample_byte     = rx;
            r.sample_position = off[8:0];
            r.frame_last      = (off + 1 >= 2 * int'(hdr_count));
            sample_expect_q.push_back(r);
            pkt_offset = r.frame_last ? 10'd0 : pkt_offset + 10'd1;
        end
    endtask

    task automatic check_sample(input sample_xfer_t got);
        sample_xfer_t want;
        if (sample_expect_q.size() == 0)
        begin
            report_error($sformatf("result transfer with nothing expected (position %0d)",
                                   got.sample_position));
            return;
        end
        want = sample_expect_q.pop_front();
        compare_field("has_sample", got.has_sample, want.has_sample);
        compare_field("sample_byte", got.sample_byte, want.sample_byte);
        compare_field("sample_position", got.sample_position, want.sample_position);
        compare_field("packet_header", got.packet_header, want.packet_header);
        compare_field("packet_type", got.packet_type, want.packet_type);
        compare_field("sample_count", got.sample_count, want.sample_count);
        compare_field("start_angle", got.start_angle, want.start_angle);
        compare_field("end_angle", got.end_angle, want.end_angle);
        compare_field("check_word", got.check_word, want.check_word);
        compare_field("frame_last", got.frame_last, want.frame_last);
        compare_field("frame_usable", got.frame_usable, want.frame_usable);
        samples_checked++;
    endtask

    // Queues one packet: ten header bytes, then 2*lsn random payload bytes.
    task automatic queue_packet(input logic [15:0] hdr, input logic [7:0] ptype,
                                input logic [7:0] lsn, input logic [15:0] sa,
                                input logic [15:0] ea, input logic [15:0] chk);
        int unsigned i;
        rx_stream_q.push_back(hdr[7:0]);
        rx_stream_q.push_back(hdr[15:8]);
        rx_stream_q.push_back(ptype);
        rx_stream_q.push_back(lsn);
        rx_stream_q.push_back(sa[7:0]);
        rx_stream_q.push_back(sa[15:8]);
        rx_stream_q.push_back(ea[7:0]);
        rx_stream_q.push_back(ea[15:8]);
        rx_stream_q.push_back(chk[7:0]);
        rx_stream_q.push_back(chk[15:8]);
        for (i = 0; i < 2 * int'(lsn); i++)
        begin
            rx_stream_q.push_back(8'($urandom_range(255)));
        end
        bytes_queued += HDR_LEN + 2 * int'(lsn);
    endtask

    // Mostly short packets; some empty ones and a few of any length up to the maximum.
    task automatic queue_random_packets(input int unsigned budget);
        int unsigned start_count;
        int unsigned pick;
        logic [7:0]  lsn;
        start_count = bytes_queued;
        while (bytes_queued - start_count < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                lsn = 8'($urandom_range(255));
            end
            else if (pick < 20)
            begin
                lsn = 8'd0;
            end
            else
            begin
                lsn = 8'($urandom_range(6, 1));
            end
            queue_packet(16'($urandom_range(16'hFFFF)), 8'($urandom_range(255)), lsn,
                         16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                         16'($urandom_range(16'hFFFF)));
        end
    endtask

    // Sampled on the falling edge so that the rising-edge processes have settled.
    task automatic wait_until_drained();
        do
        begin
            @(negedge clk);
        end
        while (rx_stream_q.size() != 0 || s_axis_tvalid || sample_expect_q.size() != 0);
    endtask

    // Sender: a byte stays offered until its transfer completes, then the next one may
    // follow in the next cycle unless the sender chooses to idle.
    always @(posedge clk or negedge rst_n)
    begin : sender_proc
        logic       offer;
        logic [7:0] offer_byte;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
        end
        else
        begin
            offer      = s_axis_tvalid && !s_axis_tready;
            offer_byte = s_axis_tdata;
            if (!offer && rx_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offer      = 1'b1;
                offer_byte = rx_stream_q.pop_front();
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= offer_byte;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver_proc
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall: the result register fills and the input side must back off.
    initial
    begin : hold_proc
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        hold_done = 1'b1;
    end

    // Checks result transfers first, then predicts from the input transfer of the same edge;
    // a result never leaves in the cycle its byte arrives.
    always @(posedge clk)
    begin : monitor_proc
        sample_xfer_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.has_sample      = m_axis_tuser[USER_HAS_SAMPLE];
                got.sample_byte     = m_axis_tdata[7:0];
                got.sample_position = m_axis_tdata[16:8];
                got.packet_header   = m_axis_tdata[32:17];
                got.packet_type     = m_axis_tdata[40:33];
                got.sample_count    = m_axis_tdata[48:41];
                got.start_angle     = m_axis_tdata[64:49];
                got.end_angle       = m_axis_tdata[80:65];
                got.check_word      = m_axis_tdata[96:81];
                got.frame_last      = m_axis_tlast;
                got.frame_usable    = m_axis_tuser[USER_USABLE];
                if (got.frame_last)
                begin
                    frames_closed++;
                end
                if (!got.has_sample)
                begin
                    empty_frames++;
                end
                check_sample(got);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                deframe_byte(s_axis_tdata);
                bytes_accepted++;
            end
        end
    end

    initial
    begin : stimulus_proc
        int unsigned k;

        // Phase one: light sender idling, heavy receiver stalls.
        send_idle_pct = 15;
        recv_idle_pct = 67;
        for (k = HUNT_LEN; k > 0; k--)
        begin
            rx_stream_q.push_back(HUNT_PREAMBLE[(k-1)*8 +: 8]);
        end
        bytes_queued = HUNT_LEN;
        // Two empty packets back to back, then one sample (not usable), two samples,
        // and a packet of maximum length.
        queue_packet(16'hFFFF, 8'h00, 8'd0, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_packet(16'h0000, 8'hFF, 8'd0, 16'hFFFF, 16'h0000, 16'h0000);
        queue_packet(16'h55AA, 8'hFF, 8'd1, 16'hFFFF, 16'h0000, 16'h8001);
        queue_packet(16'hA55A, 8'h81, 8'd2, 16'h0001, 16'h8000, 16'h7FFE);
        queue_packet(16'h55AA, 8'h40, 8'd255, 16'h1234, 16'hFEDC, 16'hA5A5);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        queue_random_packets(RANDOM_BYTES_PER_PHASE);
        wait_until_drained();

        // Phase two: the roles swap.
        send_idle_pct = 67;
        recv_idle_pct = 15;
        queue_random_packets(RANDOM_BYTES_PER_PHASE);
        wait_until_drained();

        // Phase three: full rate, with one long receiver stall while the sender keeps going.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_packet(16'h55AA, 8'h5A, 8'd40, 16'($urandom_range(16'hFFFF)),
                     16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
        queue_random_packets(RANDOM_BYTES_PER_PHASE);
        hold_request = 1'b1;
        wait (hold_done);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sample_expect_q.size() != 0)
        begin
            report_error($sformatf("%0d expected transfers never arrived",
                                   sample_expect_q.size()));
        end

        $display("Run covered the descriptor hunt and %0d stream bytes, giving %0d result",
                 bytes_accepted, samples_checked);
        $display("transfers over %0d closed packets (%0d empty); %0d mismatches.",
                 frames_closed, empty_frames, error_count);
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin : watchdog_proc
        #TIMEOUT_NS;
        $display("Timeout: stream did not drain, %0d transfers still expected",
                 sample_expect_q.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
